// ----- rtl/pre_pkg.sv -----
// Package for the printable run extractor: sizes, constants, register
// indexes, state codes and the request structs of both channels.
// No dependencies.
package pre_pkg;

  localparam int MAX_HOLD  = 16;
  localparam int LEN_W     = $clog2(MAX_HOLD + 1);
  localparam int IDX_W     = $clog2(MAX_HOLD);
  localparam int MINLEN_W  = 5;
  localparam int CMP_W     = (LEN_W > MINLEN_W) ? LEN_W : MINLEN_W;
  localparam int OFFS_W    = 32;
  localparam int ADDR_W    = 3;
  localparam int DATA_W    = 32;

  localparam logic [MINLEN_W-1:0] MIN_LENGTH_RESET = MINLEN_W'(4);
  localparam logic [7:0]          PRINT_LO         = 8'h20;
  localparam logic [7:0]          PRINT_HI         = 8'h7E;

  typedef enum logic [0:0] {
    REG_MIN_LENGTH    = 1'b0,
    REG_OFFSET_ENABLE = 1'b1
  } reg_idx_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_FLUSH_RD,
    ST_FLUSH_WR,
    ST_MARK
  } state_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_stream;
  } src_t;

  typedef struct packed {
    logic [7:0]        out_byte;
    logic              is_end_marker;
    logic              first_of_run;
    logic [OFFS_W-1:0] run_offset;
    logic              last;
  } res_t;

endpackage

// ----- rtl/printable_run_extractor.sv -----
// Printable run extractor: filters a byte stream down to printable runs of at
// least min_length bytes (1 if zero, MAX_HOLD at most), with end markers and
// optional start offsets. Depends on pre_pkg.
//
//   channel  signals                          direction  carries
//   src      src_valid/src_ready/src_data     in         raw byte, end of stream
//   res      res_valid/res_ready/res_data     out        run byte or end marker
//   cfg      psel/penable/pwrite/paddr/...    in/out     min_length, offset_enable
//
// A byte that qualifies a run of k held bytes starts a flush: the hold memory
// is read one byte at a time, each read (ST_FLUSH_RD) followed by its write-out
// (ST_FLUSH_WR), then an end marker (ST_MARK) is added if the stream ended.
// rst is synchronous; the hold memory needs no clearing after reset.
// A stalled result holds src_ready low until it is taken.
module printable_run_extractor (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        src_valid,
  output logic                        src_ready,
  input  pre_pkg::src_t               src_data,
  output logic                        res_valid,
  input  logic                        res_ready,
  output pre_pkg::res_t               res_data,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [pre_pkg::ADDR_W-1:0]  paddr,
  input  logic [pre_pkg::DATA_W-1:0]  pwdata,
  output logic [pre_pkg::DATA_W-1:0]  prdata,
  output logic                        pready
);

  pre_pkg::state_t                    state, state_next;
  logic                               res_valid_next;
  pre_pkg::res_t                      res_data_next;
  logic                               in_run, in_run_next;
  logic                               run_qualified, run_qualified_next;
  logic [pre_pkg::LEN_W-1:0]          run_length, run_length_next;
  logic [pre_pkg::OFFS_W-1:0]         byte_offset, byte_offset_next;
  logic [pre_pkg::OFFS_W-1:0]         run_start, run_start_next;
  logic                               eos_pend, eos_pend_next;
  logic [pre_pkg::LEN_W-1:0]          rd_cnt, rd_cnt_next;
  logic [pre_pkg::LEN_W-1:0]          flush_len, flush_len_next;
  logic [pre_pkg::MINLEN_W-1:0]       min_length;
  logic                               offset_enable;

  logic [7:0]                         hold_mem [pre_pkg::MAX_HOLD];
  logic                               mem_we, mem_re;
  logic [pre_pkg::IDX_W-1:0]          mem_waddr, mem_raddr;
  logic [7:0]                         mem_wdata, mem_rdata;

  logic                               res_free, src_fire, printable, cfg_write;
  logic [pre_pkg::CMP_W-1:0]          min_ext;
  logic [pre_pkg::LEN_W-1:0]          eff_min, cur_len, new_len;
  logic                               cur_qual, flush_done;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      min_length    <= pre_pkg::MIN_LENGTH_RESET;
      offset_enable <= 1'b0;
    end else if (cfg_write) begin
      case (paddr[2])
        pre_pkg::REG_MIN_LENGTH:    min_length    <= pwdata[pre_pkg::MINLEN_W-1:0];
        pre_pkg::REG_OFFSET_ENABLE: offset_enable <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      pre_pkg::REG_MIN_LENGTH:    prdata = pre_pkg::DATA_W'(min_length);
      pre_pkg::REG_OFFSET_ENABLE: prdata = pre_pkg::DATA_W'(offset_enable);
      default:                    prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      hold_mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      mem_rdata <= hold_mem[mem_raddr];
    end
  end

  always_comb begin
    min_ext = pre_pkg::CMP_W'(min_length);
    if (min_ext == '0) begin
      eff_min = pre_pkg::LEN_W'(1);
    end else if (min_ext > pre_pkg::CMP_W'(pre_pkg::MAX_HOLD)) begin
      eff_min = pre_pkg::LEN_W'(pre_pkg::MAX_HOLD);
    end else begin
      eff_min = pre_pkg::LEN_W'(min_ext);
    end
  end

  assign res_free  = !res_valid || res_ready;
  assign src_ready = (state == pre_pkg::ST_IDLE) && res_free;
  assign src_fire  = src_valid && src_ready;
  assign printable = (src_data.data_byte >= pre_pkg::PRINT_LO) &&
                     (src_data.data_byte <= pre_pkg::PRINT_HI);
  assign cur_len   = in_run ? run_length : '0;
  assign cur_qual  = in_run && run_qualified;
  assign new_len   = cur_len + pre_pkg::LEN_W'(1);
  assign flush_done = (rd_cnt + pre_pkg::LEN_W'(1)) == flush_len;
  assign mem_raddr = rd_cnt[pre_pkg::IDX_W-1:0];
  assign mem_waddr = cur_len[pre_pkg::IDX_W-1:0];
  assign mem_wdata = src_data.data_byte;

  always_comb begin
    state_next         = state;
    res_valid_next     = res_valid && !res_ready;
    res_data_next      = res_data;
    in_run_next        = in_run;
    run_qualified_next = run_qualified;
    run_length_next    = run_length;
    byte_offset_next   = byte_offset;
    run_start_next     = run_start;
    eos_pend_next      = eos_pend;
    rd_cnt_next        = rd_cnt;
    flush_len_next     = flush_len;
    mem_we             = 1'b0;
    mem_re             = 1'b0;

    case (state)
      pre_pkg::ST_IDLE: begin
        if (src_fire) begin
          if (printable) begin
            in_run_next = 1'b1;
            if (!in_run) begin
              run_start_next = byte_offset;
            end
            if (cur_qual) begin
              res_valid_next         = 1'b1;
              res_data_next          = '0;
              res_data_next.out_byte = src_data.data_byte;
              res_data_next.last     = !src_data.end_of_stream;
              if (src_data.end_of_stream) begin
                state_next = pre_pkg::ST_MARK;
              end
            end else begin
              mem_we          = 1'b1;
              run_length_next = new_len;
              run_qualified_next = 1'b0;
              if (new_len >= eff_min) begin
                run_qualified_next = 1'b1;
                flush_len_next     = new_len;
                rd_cnt_next        = '0;
                eos_pend_next      = src_data.end_of_stream;
                state_next         = pre_pkg::ST_FLUSH_RD;
              end
            end
          end else begin
            if (cur_qual) begin
              res_valid_next              = 1'b1;
              res_data_next               = '0;
              res_data_next.is_end_marker = 1'b1;
              res_data_next.last          = 1'b1;
            end
            in_run_next        = 1'b0;
            run_qualified_next = 1'b0;
            run_length_next    = '0;
          end
          if (src_data.end_of_stream) begin
            in_run_next        = 1'b0;
            run_qualified_next = 1'b0;
            run_length_next    = '0;
            byte_offset_next   = '0;
          end else begin
            byte_offset_next = byte_offset + pre_pkg::OFFS_W'(1);
          end
        end
      end
      pre_pkg::ST_FLUSH_RD: begin
        mem_re     = 1'b1;
        state_next = pre_pkg::ST_FLUSH_WR;
      end
      pre_pkg::ST_FLUSH_WR: begin
        if (res_free) begin
          res_valid_next             = 1'b1;
          res_data_next              = '0;
          res_data_next.out_byte     = mem_rdata;
          res_data_next.first_of_run = (rd_cnt == '0);
          res_data_next.run_offset   = ((rd_cnt == '0) && offset_enable) ? run_start : '0;
          res_data_next.last         = flush_done && !eos_pend;
          rd_cnt_next                = rd_cnt + pre_pkg::LEN_W'(1);
          if (flush_done) begin
            state_next = eos_pend ? pre_pkg::ST_MARK : pre_pkg::ST_IDLE;
          end else begin
            state_next = pre_pkg::ST_FLUSH_RD;
          end
        end
      end
      pre_pkg::ST_MARK: begin
        if (res_free) begin
          res_valid_next              = 1'b1;
          res_data_next               = '0;
          res_data_next.is_end_marker = 1'b1;
          res_data_next.last          = 1'b1;
          state_next                  = pre_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = pre_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= pre_pkg::ST_IDLE;
      res_valid     <= 1'b0;
      in_run        <= 1'b0;
      run_qualified <= 1'b0;
      run_length    <= '0;
      byte_offset   <= '0;
      run_start     <= '0;
      eos_pend      <= 1'b0;
      rd_cnt        <= '0;
      flush_len     <= '0;
    end else begin
      state         <= state_next;
      res_valid     <= res_valid_next;
      in_run        <= in_run_next;
      run_qualified <= run_qualified_next;
      run_length    <= run_length_next;
      byte_offset   <= byte_offset_next;
      run_start     <= run_start_next;
      eos_pend      <= eos_pend_next;
      rd_cnt        <= rd_cnt_next;
      flush_len     <= flush_len_next;
    end
  end

  always_ff @(posedge clk) begin
    res_data <= res_data_next;
  end

  a_flush_read_then_write: assert property (@(posedge clk) disable iff (rst)
    state == pre_pkg::ST_FLUSH_RD |=> state == pre_pkg::ST_FLUSH_WR)
    else $error("flush read not followed by its write-out cycle");

  a_qualified_in_run: assert property (@(posedge clk) disable iff (rst)
    run_qualified |-> in_run)
    else $error("run qualified outside a run");

  a_hold_not_full: assert property (@(posedge clk) disable iff (rst)
    (in_run && !run_qualified) |-> run_length < pre_pkg::LEN_W'(pre_pkg::MAX_HOLD))
    else $error("unqualified run filled the hold memory");

  a_marker_form: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res_data.is_end_marker) |->
      (res_data.out_byte == '0 && !res_data.first_of_run && res_data.last))
    else $error("malformed end marker");

  a_busy_blocks_src: assert property (@(posedge clk) disable iff (rst)
    state != pre_pkg::ST_IDLE |-> !src_ready)
    else $error("byte accepted during flush");

endmodule
